@@ rtl/core/spot_light_attenuation_defines.svh @@
// Assertion macros for the spot light attenuation block.
// Expects clk and rst in scope at the point of use.
`ifndef SPOT_LIGHT_ATTENUATION_DEFINES_SVH
`define SPOT_LIGHT_ATTENUATION_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SLA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sla_pkg.sv @@
// Shared constants and types for the spot light attenuation block.
// No dependencies; imported by every module of the block.
package sla_pkg;

  // Pipelined square root: one result bit per stage
  localparam int SQRT_IN_W  = 64;
  localparam int SQRT_OUT_W = SQRT_IN_W / 2;
  localparam int SQRT_STEPS = SQRT_OUT_W;

  // Pipelined restoring divider: one quotient bit per stage
  localparam int DIV_Q_W    = 17;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_NUM_W  = DIV_Q_W + DIV_DEN_W;
  localparam int DIV_STEPS  = DIV_Q_W;

  // Fixed point units
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [33:0] HALF_Q16 = 34'd32768;
  localparam logic [14:0] ONE_Q14  = 15'd16384;
  localparam logic [34:0] HALF_Q14 = 35'd8192;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LIGHT_POS_X  = 3'd0,
    REG_LIGHT_POS_Y  = 3'd1,
    REG_LIGHT_POS_Z  = 3'd2,
    REG_LIGHT_DIR_X  = 3'd3,
    REG_LIGHT_DIR_Y  = 3'd4,
    REG_LIGHT_DIR_Z  = 3'd5,
    REG_LIGHT_RADIUS = 3'd6,
    REG_CONE_COS     = 3'd7
  } cfg_reg_t;

  // How the cone factor is formed
  typedef enum logic [1:0] {
    CONE_ZERO = 2'd0,
    CONE_FULL = 2'd1,
    CONE_DIV  = 2'd2
  } cone_mode_t;

endpackage

@@ rtl/core/sla_isqrt.sv @@
// Pipelined integer square root, floor of the root of a 64-bit value.
// Depends on sla_pkg; one root bit is settled in each register stage.
module sla_isqrt
  import sla_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQRT_IN_W-1:0]  radicand,
  output logic [SQRT_OUT_W-1:0] root
);

  logic [SQRT_IN_W-1:0]  rem [SQRT_STEPS];
  logic [SQRT_OUT_W-1:0] rt  [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam int BIT = SQRT_STEPS - 1 - s;
    logic [SQRT_IN_W-1:0]  rem_in;
    logic [SQRT_OUT_W-1:0] rt_in;
    logic [SQRT_IN_W-1:0]  trial;
    logic                  fits;

    if (s == 0) begin : g_first
      assign rem_in = radicand;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem[s-1];
      assign rt_in  = rt[s-1];
    end

    // Growth of the square when this root bit is set
    assign trial = (SQRT_IN_W'(rt_in) << (BIT + 1)) | (SQRT_IN_W'(1) << (2 * BIT));
    assign fits  = rem_in >= trial;

    // Keep the bit when the remainder covers it
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= fits ? rem_in - trial : rem_in;
        rt[s]  <= fits ? (rt_in | (SQRT_OUT_W'(1) << BIT)) : rt_in;
      end
    end
  end

  assign root = rt[SQRT_STEPS-1];

endmodule

@@ rtl/core/sla_div.sv @@
// Pipelined restoring divider, 17 quotient bits over a 32-bit divisor.
// Depends on sla_pkg; the top bits of the numerator must be below the divisor.
module sla_div
  import sla_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_Q_W-1:0]   quot
);

  logic [DIV_DEN_W-1:0] rem [DIV_STEPS];
  logic [DIV_DEN_W-1:0] dvs [DIV_STEPS];
  logic [DIV_Q_W-1:0]   lo  [DIV_STEPS];
  logic [DIV_Q_W-1:0]   qt  [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_Q_W-1:0]   lo_in;
    logic [DIV_Q_W-1:0]   q_in;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    if (s == 0) begin : g_first
      assign rem_in = num[DIV_NUM_W-1 -: DIV_DEN_W];
      assign lo_in  = num[DIV_Q_W-1:0];
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem[s-1];
      assign lo_in  = lo[s-1];
      assign q_in   = qt[s-1];
      assign den_in = dvs[s-1];
    end

    // Bring down the next numerator bit and try the subtract
    assign trial = {rem_in, lo_in[DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= fits ? DIV_DEN_W'(trial - {1'b0, den_in}) : trial[DIV_DEN_W-1:0];
        dvs[s] <= den_in;
        lo[s]  <= {lo_in[DIV_Q_W-2:0], 1'b0};
        qt[s]  <= {q_in[DIV_Q_W-2:0], fits};
      end
    end
  end

  assign quot = qt[DIV_STEPS-1];

endmodule

@@ rtl/core/spot_light_attenuation.sv @@
// Spot light attenuation: one surface point per cycle in, one result per point out.
// Most of the pipe is the 32-stage square root for
// the distance and the two 17-stage divider ranks behind it (unit vector and ratio, then cone factor).
// All stages advance together; while a result waits at the output the whole pipe holds.
// Configuration writes take effect at once and are meant for an idle pipe.
// Depends on sla_pkg, sla_isqrt, sla_div and spot_light_attenuation_defines.svh.
`include "spot_light_attenuation_defines.svh"

module spot_light_attenuation
  import sla_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Point request: point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,
  // Result: to_light_x [15:0], to_light_y [31:16], to_light_z [47:32],
  // distance [79:48], attenuation [96:80], zero fill [103:97]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,
  // Configuration writes
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [2:0]  neg;
    logic        sat;
  } sq_sb_t;

  typedef struct packed {
    logic [31:0] d;
    logic        lit;
    logic [2:0]  neg;
    logic        dzero;
    logic        rzero;
  } dv_sb_t;

  typedef struct packed {
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic [31:0] d;
    logic        lit;
    cone_mode_t  mode;
    logic [16:0] t2;
  } cn_sb_t;

  // Configuration registers
  logic [31:0] light_pos_x, light_pos_y, light_pos_z;
  logic [15:0] light_dir_x, light_dir_y, light_dir_z;
  logic [30:0] light_radius;
  logic [31:0] cone_cosines;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_pos_x  <= '0;
      light_pos_y  <= '0;
      light_pos_z  <= '0;
      light_dir_x  <= '0;
      light_dir_y  <= '0;
      light_dir_z  <= 16'hC000;
      light_radius <= 31'd65536;
      cone_cosines <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIGHT_POS_X:  light_pos_x  <= cfg_data;
        REG_LIGHT_POS_Y:  light_pos_y  <= cfg_data;
        REG_LIGHT_POS_Z:  light_pos_z  <= cfg_data;
        REG_LIGHT_DIR_X:  light_dir_x  <= cfg_data[15:0];
        REG_LIGHT_DIR_Y:  light_dir_y  <= cfg_data[15:0];
        REG_LIGHT_DIR_Z:  light_dir_z  <= cfg_data[15:0];
        REG_LIGHT_RADIUS: light_radius <= cfg_data[30:0];
        REG_CONE_COS:     cone_cosines <= cfg_data;
      endcase
    end
  end

  // Global advance: hold everything while the result is not taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Valid bits of the single stages
  logic a_vld, b_vld, c_vld, d_vld, e_vld;
  logic f_vld, g_vld, h_vld, i_vld, j_vld, k_vld, l_vld;
  logic [SQRT_STEPS-1:0] sq_vld;
  logic [DIV_STEPS-1:0]  dv_vld;
  logic [DIV_STEPS-1:0]  cn_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld    <= 1'b0;
      b_vld    <= 1'b0;
      c_vld    <= 1'b0;
      d_vld    <= 1'b0;
      sq_vld   <= '0;
      e_vld    <= 1'b0;
      dv_vld   <= '0;
      f_vld    <= 1'b0;
      g_vld    <= 1'b0;
      h_vld    <= 1'b0;
      i_vld    <= 1'b0;
      j_vld    <= 1'b0;
      cn_vld   <= '0;
      k_vld    <= 1'b0;
      l_vld    <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      a_vld    <= s_tvalid;
      b_vld    <= a_vld;
      c_vld    <= b_vld;
      d_vld    <= c_vld;
      sq_vld   <= {sq_vld[SQRT_STEPS-2:0], d_vld};
      e_vld    <= sq_vld[SQRT_STEPS-1];
      dv_vld   <= {dv_vld[DIV_STEPS-2:0], e_vld};
      f_vld    <= dv_vld[DIV_STEPS-1];
      g_vld    <= f_vld;
      h_vld    <= g_vld;
      i_vld    <= h_vld;
      j_vld    <= i_vld;
      cn_vld   <= {cn_vld[DIV_STEPS-2:0], j_vld};
      k_vld    <= cn_vld[DIV_STEPS-1];
      l_vld    <= k_vld;
      m_tvalid <= l_vld;
    end
  end

  // Stage A: offsets from point to light
  logic [32:0] a_dx, a_dy, a_dz;
  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= {light_pos_x[31], light_pos_x} - {s_tdata[31], s_tdata[31:0]};
      a_dy <= {light_pos_y[31], light_pos_y} - {s_tdata[63], s_tdata[63:32]};
      a_dz <= {light_pos_z[31], light_pos_z} - {s_tdata[95], s_tdata[95:64]};
    end
  end

  // Stage B: magnitudes and signs
  logic [31:0] b_ax, b_ay, b_az;
  logic [2:0]  b_neg;
  always_ff @(posedge clk) begin
    if (en) begin
      b_ax  <= a_dx[32] ? 32'(-a_dx) : a_dx[31:0];
      b_ay  <= a_dy[32] ? 32'(-a_dy) : a_dy[31:0];
      b_az  <= a_dz[32] ? 32'(-a_dz) : a_dz[31:0];
      b_neg <= {a_dz[32], a_dy[32], a_dx[32]};
    end
  end

  // Stage C: squares
  logic [63:0] c_sx, c_sy, c_sz;
  logic [31:0] c_ax, c_ay, c_az;
  logic [2:0]  c_neg;
  always_ff @(posedge clk) begin
    if (en) begin
      c_sx  <= b_ax * b_ax;
      c_sy  <= b_ay * b_ay;
      c_sz  <= b_az * b_az;
      c_ax  <= b_ax;
      c_ay  <= b_ay;
      c_az  <= b_az;
      c_neg <= b_neg;
    end
  end

  // Stage D: sum of squares, flag overflow past 64 bits
  logic [65:0] c_sum;
  logic [63:0] d_sum;
  sq_sb_t      d_sb;
  assign c_sum = 66'(c_sx) + 66'(c_sy) + 66'(c_sz);
  always_ff @(posedge clk) begin
    if (en) begin
      d_sum     <= c_sum[63:0];
      d_sb.ax   <= c_ax;
      d_sb.ay   <= c_ay;
      d_sb.az   <= c_az;
      d_sb.neg  <= c_neg;
      d_sb.sat  <= |c_sum[65:64];
    end
  end

  // Distance root, with the offsets carried alongside
  logic [SQRT_OUT_W-1:0] sq_root;
  sq_sb_t                sq_sb [SQRT_STEPS];

  sla_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (d_sum),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sb[0] <= d_sb;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq_sb[k] <= sq_sb[k-1];
      end
    end
  end

  // Stage E: distance, radius test, divider operands
  sq_sb_t      sq_out;
  logic [31:0] dist_cur;
  logic [31:0] e_d;
  logic        e_lit, e_dzero, e_rzero;
  logic [2:0]  e_neg;
  logic [DIV_NUM_W-1:0] e_nx, e_ny, e_nz, e_nq;

  assign sq_out   = sq_sb[SQRT_STEPS-1];
  assign dist_cur = sq_out.sat ? '1 : sq_root;

  always_ff @(posedge clk) begin
    if (en) begin
      e_d     <= dist_cur;
      e_lit   <= dist_cur <= {1'b0, light_radius};
      e_dzero <= dist_cur == '0;
      e_rzero <= light_radius == '0;
      e_neg   <= sq_out.neg;
      e_nx    <= {3'b0, sq_out.ax, 14'b0} + DIV_NUM_W'(dist_cur >> 1);
      e_ny    <= {3'b0, sq_out.ay, 14'b0} + DIV_NUM_W'(dist_cur >> 1);
      e_nz    <= {3'b0, sq_out.az, 14'b0} + DIV_NUM_W'(dist_cur >> 1);
      e_nq    <= {1'b0, dist_cur, 16'b0} + DIV_NUM_W'(light_radius >> 1);
    end
  end

  // Unit vector components and distance ratio
  logic [DIV_Q_W-1:0] qx, qy, qz, qr;
  dv_sb_t             e_sb;
  dv_sb_t             dv_sb [DIV_STEPS];

  sla_div u_div_x (.clk(clk), .en(en), .num(e_nx), .den(e_d), .quot(qx));
  sla_div u_div_y (.clk(clk), .en(en), .num(e_ny), .den(e_d), .quot(qy));
  sla_div u_div_z (.clk(clk), .en(en), .num(e_nz), .den(e_d), .quot(qz));
  sla_div u_div_r (
    .clk  (clk),
    .en   (en),
    .num  (e_nq),
    .den  ({1'b0, light_radius}),
    .quot (qr)
  );

  assign e_sb = '{d: e_d, lit: e_lit, neg: e_neg, dzero: e_dzero, rzero: e_rzero};

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sb[0] <= e_sb;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_sb[k] <= dv_sb[k-1];
      end
    end
  end

  // Stage F: clamp and sign the unit vector, clamp the ratio
  dv_sb_t      dv_out;
  logic [14:0] mag_x, mag_y, mag_z;
  logic [15:0] f_tx, f_ty, f_tz;
  logic [16:0] f_q;
  logic [31:0] f_d;
  logic        f_lit;

  assign dv_out = dv_sb[DIV_STEPS-1];

  always_comb begin
    mag_x = (qx > 17'(ONE_Q14)) ? ONE_Q14 : qx[14:0];
    mag_y = (qy > 17'(ONE_Q14)) ? ONE_Q14 : qy[14:0];
    mag_z = (qz > 17'(ONE_Q14)) ? ONE_Q14 : qz[14:0];
    if (dv_out.dzero) begin
      mag_x = '0;
      mag_y = '0;
      mag_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_tx  <= dv_out.neg[0] ? -{1'b0, mag_x} : {1'b0, mag_x};
      f_ty  <= dv_out.neg[1] ? -{1'b0, mag_y} : {1'b0, mag_y};
      f_tz  <= dv_out.neg[2] ? -{1'b0, mag_z} : {1'b0, mag_z};
      f_q   <= dv_out.rzero ? '0 : ((qr > ONE_Q16) ? ONE_Q16 : qr);
      f_d   <= dv_out.d;
      f_lit <= dv_out.lit;
    end
  end

  // Stage G: direction products and ratio square
  logic signed [31:0] g_px, g_py, g_pz;
  logic [33:0]        g_qq;
  logic [15:0]        g_tx, g_ty, g_tz;
  logic [31:0]        g_d;
  logic               g_lit;
  always_ff @(posedge clk) begin
    if (en) begin
      g_px  <= $signed(f_tx) * $signed(light_dir_x);
      g_py  <= $signed(f_ty) * $signed(light_dir_y);
      g_pz  <= $signed(f_tz) * $signed(light_dir_z);
      g_qq  <= f_q * f_q;
      g_tx  <= f_tx;
      g_ty  <= f_ty;
      g_tz  <= f_tz;
      g_d   <= f_d;
      g_lit <= f_lit;
    end
  end

  // Stage H: dot product, one minus ratio squared
  logic signed [33:0] h_dot;
  logic [16:0]        h_t;
  logic [15:0]        h_tx, h_ty, h_tz;
  logic [31:0]        h_d;
  logic               h_lit;
  always_ff @(posedge clk) begin
    if (en) begin
      h_dot <= 34'(g_px) + 34'(g_py) + 34'(g_pz);
      h_t   <= ONE_Q16 - 17'((g_qq + HALF_Q16) >> 16);
      h_tx  <= g_tx;
      h_ty  <= g_ty;
      h_tz  <= g_tz;
      h_d   <= g_d;
      h_lit <= g_lit;
    end
  end

  // Stage I: round the negated dot product to Q1.14, square the falloff base
  logic signed [34:0] neg_dot;
  logic signed [20:0] i_c;
  logic [33:0]        i_tt;
  logic [15:0]        i_tx, i_ty, i_tz;
  logic [31:0]        i_d;
  logic               i_lit;

  assign neg_dot = -35'(h_dot) + $signed(HALF_Q14);

  always_ff @(posedge clk) begin
    if (en) begin
      i_c   <= 21'(neg_dot >>> 14);
      i_tt  <= h_t * h_t;
      i_tx  <= h_tx;
      i_ty  <= h_ty;
      i_tz  <= h_tz;
      i_d   <= h_d;
      i_lit <= h_lit;
    end
  end

  // Stage J: cone test and cone divider operands
  logic signed [15:0] cos_inner, cos_outer;
  logic signed [21:0] cone_x;
  logic signed [16:0] cone_den;
  cone_mode_t         cone_mode;
  logic [DIV_NUM_W-1:0] j_n;
  logic [DIV_DEN_W-1:0] j_den;
  cn_sb_t             j_sb;

  assign cos_inner = cone_cosines[31:16];
  assign cos_outer = cone_cosines[15:0];
  assign cone_x    = 22'(i_c) - 22'(cos_outer);
  assign cone_den  = 17'(cos_inner) - 17'(cos_outer);

  always_comb begin
    priority if (cone_den < 0) begin
      cone_mode = CONE_ZERO;
    end else if (cone_den == 0 || cone_x >= 22'(cone_den)) begin
      cone_mode = CONE_FULL;
    end else begin
      cone_mode = CONE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_n       <= {17'b0, cone_x[15:0], 16'b0} + DIV_NUM_W'(cone_den[16:1]);
      j_den     <= DIV_DEN_W'(cone_den[15:0]);
      j_sb.tx   <= i_tx;
      j_sb.ty   <= i_ty;
      j_sb.tz   <= i_tz;
      j_sb.d    <= i_d;
      j_sb.lit  <= i_lit && !cone_x[21];
      j_sb.mode <= cone_mode;
      j_sb.t2   <= 17'((i_tt + HALF_Q16) >> 16);
    end
  end

  // Cone factor division
  logic [DIV_Q_W-1:0] qa;
  cn_sb_t             cn_sb [DIV_STEPS];

  sla_div u_div_cone (.clk(clk), .en(en), .num(j_n), .den(j_den), .quot(qa));

  always_ff @(posedge clk) begin
    if (en) begin
      cn_sb[0] <= j_sb;
      for (int k = 1; k < DIV_STEPS; k++) begin
        cn_sb[k] <= cn_sb[k-1];
      end
    end
  end

  // Stage K: select the cone factor
  cn_sb_t      cn_out;
  logic [16:0] cone_a;
  logic [16:0] k_a;
  cn_sb_t      k_sb;

  assign cn_out = cn_sb[DIV_STEPS-1];

  always_comb begin
    unique case (cn_out.mode)
      CONE_ZERO: cone_a = '0;
      CONE_FULL: cone_a = ONE_Q16;
      CONE_DIV:  cone_a = (qa > ONE_Q16) ? ONE_Q16 : qa;
      default:   cone_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_a  <= cone_a;
      k_sb <= cn_out;
    end
  end

  // Stage L: combine cone and distance factors
  logic [33:0] l_prod;
  cn_sb_t      l_sb;
  always_ff @(posedge clk) begin
    if (en) begin
      l_prod <= k_a * k_sb.t2;
      l_sb   <= k_sb;
    end
  end

  // Output register: drop direction and attenuation when unlit
  logic [15:0] out_tx, out_ty, out_tz;
  logic [31:0] out_d;
  logic [16:0] out_att;
  always_ff @(posedge clk) begin
    if (en) begin
      out_tx  <= l_sb.lit ? l_sb.tx : '0;
      out_ty  <= l_sb.lit ? l_sb.ty : '0;
      out_tz  <= l_sb.lit ? l_sb.tz : '0;
      out_d   <= l_sb.d;
      out_att <= l_sb.lit ? 17'((l_prod + HALF_Q16) >> 16) : '0;
    end
  end

  assign m_tdata = {7'b0, out_att, out_d, out_tz, out_ty, out_tx};

  // Checks
  `SLA_ASSERT_IMP(a_att_range, m_tvalid, out_att <= ONE_Q16, "attenuation above one")
  `SLA_ASSERT_IMP(a_beyond_radius, m_tvalid && (out_d > {1'b0, light_radius}), (out_att == '0) && (out_tx == '0) && (out_ty == '0) && (out_tz == '0), "lit beyond radius")
  `SLA_ASSERT_IMP(a_zero_dist, m_tvalid && (out_d == '0), (out_tx == '0) && (out_ty == '0) && (out_tz == '0), "direction at zero distance")
  `SLA_ASSERT_NXT(a_hold_pipe, !en, $stable(sq_vld) && $stable(cn_vld) && $stable(out_att), "pipe moved while held")

endmodule
